// File: hw/rtl/qcd_pkg.sv
// Shared types, constants and the pixel hash function of the QOI chunk decoder.
`default_nettype none

package qcd_pkg;

  // Widths fixed by the chunk format and the register map.
  localparam int COUNT_W   = 29;
  localparam int CHAN_W    = 8;
  localparam int NUM_CHAN  = 4;
  localparam int PIX_W     = CHAN_W * NUM_CHAN;
  localparam int IDX_DEPTH = 64;
  localparam int IDX_AW    = $clog2(IDX_DEPTH);
  localparam int PEND_W    = 3;

  // Channel positions within a pixel.
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_ALPHA = 3;

  // Tag bytes and two-bit opcodes of the chunk stream.
  localparam logic [7:0] TAG_RGB  = 8'hFE;
  localparam logic [7:0] TAG_RGBA = 8'hFF;
  localparam logic [1:0] OP_INDEX = 2'd0;
  localparam logic [1:0] OP_DIFF  = 2'd1;
  localparam logic [1:0] OP_LUMA  = 2'd2;
  localparam logic [1:0] OP_RUN   = 2'd3;

  // Data bytes that follow the RGB and RGBA tags and the LUMA opcode.
  localparam logic [PEND_W-1:0] RGB_BYTES  = 3'd3;
  localparam logic [PEND_W-1:0] RGBA_BYTES = 3'd4;
  localparam logic [PEND_W-1:0] LUMA_BYTES = 3'd1;

  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;

  // Previous pixel at the start of an image: black, fully opaque.
  localparam pixel_t PIX_RESET = {8'hFF, 8'h00, 8'h00, 8'h00};

  // Kind of a chunk whose data bytes are still arriving.
  typedef enum logic [1:0] {
    KIND_IDLE,
    KIND_RGB,
    KIND_RGBA,
    KIND_LUMA
  } kind_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load_index;
    logic emit;
    logic write_index;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go_fetch;
    logic go_emit;
    logic slot_free;
    logic run_end;
  } dp_status_t;

  // Index position of a pixel: (3r + 5g + 7b + 11a) mod 64.
  function automatic logic [IDX_AW-1:0] pixel_hash(input pixel_t p);
    logic [IDX_AW-1:0] r6;
    logic [IDX_AW-1:0] g6;
    logic [IDX_AW-1:0] b6;
    logic [IDX_AW-1:0] a6;
    r6 = p[CH_RED][IDX_AW-1:0];
    g6 = p[CH_GREEN][IDX_AW-1:0];
    b6 = p[CH_BLUE][IDX_AW-1:0];
    a6 = p[CH_ALPHA][IDX_AW-1:0];
    return IDX_AW'(r6 * IDX_AW'(3) + g6 * IDX_AW'(5) + b6 * IDX_AW'(7) + a6 * IDX_AW'(11));
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/qcd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module qcd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/qcd_ctrl.sv
// Controller state machine of the QOI chunk decoder.
`default_nettype none

module qcd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire qcd_pkg::dp_status_t status,
  output qcd_pkg::ctrl_cmd_t      cmd
);

  import qcd_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (status.go_fetch) begin
            state_next = S_FETCH;
          end else if (status.go_emit) begin
            state_next = S_EMIT;
          end
        end
      end
      S_FETCH: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.slot_free && status.run_end) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs: an item is taken only in the idle state; the index entry is
  // written throughout the emit state since the pixel does not change there.
  always_comb begin
    in_ready        = 1'b0;
    cmd             = '0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_FETCH: begin
        cmd.load_index = 1'b1;
      end
      S_EMIT: begin
        cmd.write_index = 1'b1;
        cmd.emit        = status.slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/qcd_datapath.sv
// Datapath of the QOI chunk decoder: chunk state, colour index and output register.
`default_nettype none

module qcd_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire qcd_pkg::ctrl_cmd_t            cmd,
  output qcd_pkg::dp_status_t                status,
  input  wire logic [7:0]                    data_byte,
  input  wire logic                          new_image,
  input  wire logic                          cfg_valid,
  input  wire logic [qcd_pkg::COUNT_W-1:0]   cfg_data,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [7:0]                         red,
  output logic [7:0]                         green,
  output logic [7:0]                         blue,
  output logic [7:0]                         alpha,
  output logic                               last_of_run,
  output logic                               image_done
);

  import qcd_pkg::*;

  // Architectural state.
  logic [COUNT_W-1:0] pixel_total;
  pixel_t             last_pixel;
  pixel_t             last_pixel_next;
  kind_t              chunk_kind;
  kind_t              chunk_kind_next;
  logic [PEND_W-1:0]  bytes_pending;
  logic [PEND_W-1:0]  bytes_pending_next;
  logic [5:0]         green_delta;
  logic [5:0]         green_delta_next;
  logic [COUNT_W-1:0] pixels_emitted;
  logic [COUNT_W-1:0] pixels_emitted_next;
  logic [5:0]         run_left;
  logic [5:0]         run_left_next;

  // Colour index: data in RAM, validity in flip-flops.
  logic [IDX_DEPTH-1:0] idx_valid;
  logic                 idx_clear;
  logic                 fetch_valid;
  logic [PIX_W-1:0]     ram_rdata;
  logic [IDX_AW-1:0]    hash;

  // Output register.
  pixel_t out_pixel;

  // Decode helpers.
  logic                 image_full;
  logic                 go_emit;
  logic                 go_fetch;
  logic [7:0]           vg;
  logic [PEND_W-1:0]    chunk_bytes;
  logic [1:0]           chan;
  logic [COUNT_W-1:0]   count_inc;
  logic                 done_now;

  assign hash      = pixel_hash(last_pixel);
  assign count_inc = pixels_emitted + COUNT_W'(1);
  assign done_now  = (pixel_total != '0) && (count_inc == pixel_total);

  // Status back to the controller.
  assign status.go_fetch  = go_fetch;
  assign status.go_emit   = go_emit;
  assign status.slot_free = !out_valid || out_ready;
  assign status.run_end   = (run_left == '0) || done_now;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_total <= '0;
    end else if (cfg_valid) begin
      pixel_total <= cfg_data;
    end
  end

  // Decode of an accepted byte, index load and pixel count.
  always_comb begin
    last_pixel_next     = last_pixel;
    chunk_kind_next     = chunk_kind;
    bytes_pending_next  = bytes_pending;
    green_delta_next    = green_delta;
    pixels_emitted_next = pixels_emitted;
    run_left_next       = run_left;
    idx_clear           = 1'b0;
    go_emit             = 1'b0;
    go_fetch            = 1'b0;
    image_full          = 1'b0;
    vg                  = 8'({2'b00, green_delta}) - 8'd32;
    chunk_bytes         = RGB_BYTES;
    chan                = 2'd0;

    if (cmd.accept) begin
      // A new image resets pixel, chunk, count and index before the byte is seen.
      if (new_image) begin
        last_pixel_next     = PIX_RESET;
        chunk_kind_next     = KIND_IDLE;
        bytes_pending_next  = '0;
        green_delta_next    = '0;
        pixels_emitted_next = '0;
        idx_clear           = 1'b1;
      end
      vg         = 8'({2'b00, green_delta_next}) - 8'd32;
      image_full = (pixel_total != '0) && (pixels_emitted_next >= pixel_total);

      if (!image_full) begin
        if (bytes_pending_next != '0) begin
          // Data byte of a pending chunk.
          if (chunk_kind_next == KIND_LUMA) begin
            last_pixel_next[CH_RED] = last_pixel_next[CH_RED] + vg - 8'd8
                                      + {4'b0000, data_byte[7:4]};
            last_pixel_next[CH_GREEN] = last_pixel_next[CH_GREEN] + vg;
            last_pixel_next[CH_BLUE] = last_pixel_next[CH_BLUE] + vg - 8'd8
                                       + {4'b0000, data_byte[3:0]};
          end else begin
            chunk_bytes = (chunk_kind_next == KIND_RGBA) ? RGBA_BYTES : RGB_BYTES;
            chan        = 2'(chunk_bytes - bytes_pending_next);
            last_pixel_next[chan] = data_byte;
          end
          bytes_pending_next = bytes_pending_next - PEND_W'(1);
          if (bytes_pending_next == '0) begin
            chunk_kind_next = KIND_IDLE;
            run_left_next   = '0;
            go_emit         = 1'b1;
          end
        end else if (data_byte == TAG_RGB) begin
          chunk_kind_next    = KIND_RGB;
          bytes_pending_next = RGB_BYTES;
        end else if (data_byte == TAG_RGBA) begin
          chunk_kind_next    = KIND_RGBA;
          bytes_pending_next = RGBA_BYTES;
        end else begin
          unique case (data_byte[7:6])
            OP_INDEX: begin
              run_left_next = '0;
              go_fetch      = 1'b1;
            end
            OP_DIFF: begin
              last_pixel_next[CH_RED] = last_pixel_next[CH_RED]
                                        + {6'b000000, data_byte[5:4]} - 8'd2;
              last_pixel_next[CH_GREEN] = last_pixel_next[CH_GREEN]
                                          + {6'b000000, data_byte[3:2]} - 8'd2;
              last_pixel_next[CH_BLUE] = last_pixel_next[CH_BLUE]
                                         + {6'b000000, data_byte[1:0]} - 8'd2;
              run_left_next = '0;
              go_emit       = 1'b1;
            end
            OP_LUMA: begin
              chunk_kind_next    = KIND_LUMA;
              bytes_pending_next = LUMA_BYTES;
              green_delta_next   = data_byte[5:0];
            end
            OP_RUN: begin
              run_left_next = data_byte[5:0];
              go_emit       = 1'b1;
            end
            default: begin
              go_emit = 1'b0;
            end
          endcase
        end
      end
    end

    // Entry read from the index; one never written since the image began reads zero.
    if (cmd.load_index) begin
      last_pixel_next = fetch_valid ? pixel_t'(ram_rdata) : '0;
    end

    // One pixel leaves for the output register.
    if (cmd.emit) begin
      pixels_emitted_next = count_inc;
      run_left_next       = run_left - 6'd1;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pixel     <= PIX_RESET;
      chunk_kind     <= KIND_IDLE;
      bytes_pending  <= '0;
      green_delta    <= '0;
      pixels_emitted <= '0;
      run_left       <= '0;
    end else begin
      last_pixel     <= last_pixel_next;
      chunk_kind     <= chunk_kind_next;
      bytes_pending  <= bytes_pending_next;
      green_delta    <= green_delta_next;
      pixels_emitted <= pixels_emitted_next;
      run_left       <= run_left_next;
    end
  end

  // Validity of the index entries, cleared at reset and at each new image.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx_valid <= '0;
    end else if (idx_clear) begin
      idx_valid <= '0;
    end else if (cmd.write_index) begin
      idx_valid[hash] <= 1'b1;
    end
  end

  // Validity of the entry being read, taken alongside the RAM read.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      fetch_valid <= !new_image && idx_valid[data_byte[IDX_AW-1:0]];
    end
  end

  // Colour index storage.
  qcd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (IDX_DEPTH)
  ) u_index_ram (
    .clk   (clk),
    .we    (cmd.write_index),
    .waddr (hash),
    .wdata (PIX_W'(last_pixel)),
    .re    (cmd.accept),
    .raddr (data_byte[IDX_AW-1:0]),
    .rdata (ram_rdata)
  );

  // Output register: holds one pixel until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pixel   <= last_pixel;
      last_of_run <= (run_left == '0) || done_now;
      image_done  <= done_now;
    end
  end

  assign red   = out_pixel[CH_RED];
  assign green = out_pixel[CH_GREEN];
  assign blue  = out_pixel[CH_BLUE];
  assign alpha = out_pixel[CH_ALPHA];

endmodule

`default_nettype wire

// File: hw/rtl/qoi_chunk_decoder_unit.sv
// QOI chunk decoder: takes the chunk stream a byte at a time and emits RGBA pixels.
// Sequencing: a byte that completes no pixel leaves the block free for another byte;
// a byte giving pixels holds off input until the last has entered the single output
// register, one pixel per cycle while out_ready is high; an index chunk first waits
// on the registered index RAM read. A pixel is held in the last-pixel register first.
// Reset: synchronous rst clears the pixel total, chunk state, count and index validity.
`default_nettype none

module qoi_chunk_decoder_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        new_image,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [7:0]                       red,
  output logic [7:0]                       green,
  output logic [7:0]                       blue,
  output logic [7:0]                       alpha,
  output logic                             last_of_run,
  output logic                             image_done,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [qcd_pkg::COUNT_W-1:0] cfg_data
);

  import qcd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The register accepts a write in any cycle.
  assign cfg_ready = 1'b1;

  // Sequencing of each byte.
  qcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Chunk decoding, index and output.
  qcd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .data_byte   (data_byte),
    .new_image   (new_image),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha),
    .last_of_run (last_of_run),
    .image_done  (image_done)
  );

endmodule

`default_nettype wire

// File: sim/tb_qoi_chunk_decoder_unit.sv
// Self-checking testbench of the QOI chunk decoder: byte stream in, checked pixel stream out.
`default_nettype none

module tb_qoi_chunk_decoder_unit;
  import qcd_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE      = 8;
  localparam int PHASE_ITEMS = 42;
  localparam int NUM_PHASES  = 7;
  localparam int LONG_HOLD   = 150;
  localparam int PRINT_CAP   = 100;

  // One decoded pixel as it leaves the block.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
    logic       done;
  } pix_t;

  // One row of the directed stimulus; a pixel total is written first where wr_cfg is set.
  typedef struct packed {
    logic               wr_cfg;
    logic [COUNT_W-1:0] total;
    logic               ni;
    logic [7:0]         byte_in;
    logic               typed;
    pix_t               want;
  } dir_row_t;

  localparam pix_t NO_PIX = '0;

  localparam int NUM_ROWS = 27;
  localparam dir_row_t DIRECTED [NUM_ROWS] = '{
    '{1'b1, 29'd0, 1'b1, {OP_DIFF, 6'h2A}, 1'b1, '{8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b0}},
    '{1'b0, 29'd0, 1'b0, {OP_DIFF, 6'h00}, 1'b1, '{8'hFE, 8'hFE, 8'hFE, 8'hFF, 1'b1, 1'b0}},
    '{1'b0, 29'd0, 1'b0, {OP_DIFF, 6'h3F}, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0}},
    '{1'b0, 29'd0, 1'b0, TAG_RGB, 1'b0, NO_PIX},
    '{1'b0, 29'd0, 1'b0, 8'h00, 1'b0, NO_PIX},
    '{1'b0, 29'd0, 1'b0, 8'h80, 1'b0, NO_PIX},
    '{1'b0, 29'd0, 1'b0, 8'hFF, 1'b1, '{8'h00, 8'h80, 8'hFF, 8'hFF, 1'b1, 1'b0}},
    '{1'b0, 29'd0, 1'b0, TAG_RGBA, 1'b0, NO_PIX},
    '{1'b0, 29'd0, 1'b0, 8'h12, 1'b0, NO_PIX},
    '{1'b0, 29'd0, 1'b0, 8'h34, 1'b0, NO_PIX},
    '{1'b0, 29'd0, 1'b0, 8'h56, 1'b0, NO_PIX},
    '{1'b0, 29'd0, 1'b0, 8'h00, 1'b1, '{8'h12, 8'h34, 8'h56, 8'h00, 1'b1, 1'b0}},
    '{1'b0, 29'd0, 1'b0, {OP_LUMA, 6'h00}, 1'b0, NO_PIX},
    '{1'b0, 29'd0, 1'b0, 8'h00, 1'b0, NO_PIX},
    '{1'b0, 29'd0, 1'b0, {OP_LUMA, 6'h3F}, 1'b0, NO_PIX},
    '{1'b0, 29'd0, 1'b0, 8'hFF, 1'b0, NO_PIX},
    '{1'b0, 29'd0, 1'b0, {OP_RUN, 6'd0}, 1'b0, NO_PIX},
    '{1'b0, 29'd0, 1'b0, {OP_RUN, 6'd61}, 1'b0, NO_PIX},
    '{1'b0, 29'd0, 1'b0, {OP_INDEX, 6'd63}, 1'b0, NO_PIX},
    '{1'b0, 29'd0, 1'b0, {OP_INDEX, 6'd20}, 1'b0, NO_PIX},
    '{1'b0, 29'd0, 1'b0, TAG_RGB, 1'b0, NO_PIX},
    '{1'b0, 29'd0, 1'b0, 8'h11, 1'b0, NO_PIX},
    '{1'b0, 29'd0, 1'b1, {OP_DIFF, 6'h2A}, 1'b1, '{8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b0}},
    '{1'b1, 29'd1, 1'b1, {OP_DIFF, 6'h2A}, 1'b1, '{8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1}},
    '{1'b0, 29'd1, 1'b0, {OP_RUN, 6'd5}, 1'b0, NO_PIX},
    '{1'b0, 29'd1, 1'b0, TAG_RGBA, 1'b0, NO_PIX},
    '{1'b0, 29'd1, 1'b1, {OP_RUN, 6'd61}, 1'b1, '{8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1}}
  };

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         data_byte;
  logic               new_image;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [7:0]         alpha;
  logic               last_of_run;
  logic               image_done;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data;

  // Typed expectation travelling with the item on offer.
  logic               cur_typed;
  pix_t               cur_want;

  // Decoder state kept by the testbench.
  logic [COUNT_W-1:0] total_reg;
  logic [COUNT_W-1:0] emitted;
  pixel_t             prev_pix;
  pixel_t             color_tab [IDX_DEPTH];
  kind_t              chunk;
  logic [PEND_W-1:0]  pend;
  logic [5:0]         gdelta;

  pix_t pixels_due [$];
  int   errors = 0;
  int   items_sent = 0;
  int   quiet = 0;
  int   hold_len = 0;
  bit   src_idle_on = 1'b1;
  bit   snk_idle_on = 1'b1;
  bit   force_new = 1'b0;

  qoi_chunk_decoder_unit uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .new_image   (new_image),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha),
    .last_of_run (last_of_run),
    .image_done  (image_done),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report(input string msg);
    if (errors < PRINT_CAP) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic bit image_full();
    return total_reg != '0 && emitted >= total_reg;
  endfunction

  function automatic logic [5:0] slot_of(input pixel_t p);
    return 6'(p[CH_RED] * 3 + p[CH_GREEN] * 5 + p[CH_BLUE] * 7 + p[CH_ALPHA] * 11);
  endfunction

  task automatic clear_image();
    foreach (color_tab[i]) color_tab[i] = '0;
    prev_pix = PIX_RESET;
    chunk    = KIND_IDLE;
    pend     = '0;
    gdelta   = '0;
    emitted  = '0;
  endtask

  // Indexes the current pixel and emits it up to count times, cut at the pixel total.
  task automatic emit_pixels(input int count);
    pix_t res;
    int   k;
    color_tab[slot_of(prev_pix)] = prev_pix;
    for (k = 0; k < count && !image_full(); k++) begin
      emitted   = emitted + 1'b1;
      res.red   = prev_pix[CH_RED];
      res.green = prev_pix[CH_GREEN];
      res.blue  = prev_pix[CH_BLUE];
      res.alpha = prev_pix[CH_ALPHA];
      res.done  = image_full();
      res.last  = (k == count - 1) || res.done;
      pixels_due.insert(pixels_due.size(), res);
    end
  endtask

  // Works out the pixels that one accepted byte causes.
  task automatic decode_byte(input logic [7:0] b, input logic ni);
    logic [7:0]        vg;
    logic [PEND_W-1:0] span;
    int                ch;
    if (ni) clear_image();
    if (image_full()) return;
    if (pend != '0) begin
      if (chunk == KIND_LUMA) begin
        vg = {2'b00, gdelta} - 8'd32;
        prev_pix[CH_RED]   = prev_pix[CH_RED] + vg - 8'd8 + b[7:4];
        prev_pix[CH_GREEN] = prev_pix[CH_GREEN] + vg;
        prev_pix[CH_BLUE]  = prev_pix[CH_BLUE] + vg - 8'd8 + b[3:0];
      end else begin
        // Raw channels land in the previous pixel as soon as they arrive.
        span = (chunk == KIND_RGBA) ? RGBA_BYTES : RGB_BYTES;
        ch   = int'(2'(span - pend));
        prev_pix[ch] = b;
      end
      pend = pend - 1'b1;
      if (pend == '0) begin
        chunk = KIND_IDLE;
        emit_pixels(1);
      end
    end else if (b == TAG_RGB) begin
      chunk = KIND_RGB;
      pend  = RGB_BYTES;
    end else if (b == TAG_RGBA) begin
      chunk = KIND_RGBA;
      pend  = RGBA_BYTES;
    end else begin
      case (b[7:6])
        OP_INDEX: begin
          prev_pix = color_tab[b[5:0]];
          emit_pixels(1);
        end
        OP_DIFF: begin
          prev_pix[CH_RED]   = prev_pix[CH_RED] + b[5:4] - 8'd2;
          prev_pix[CH_GREEN] = prev_pix[CH_GREEN] + b[3:2] - 8'd2;
          prev_pix[CH_BLUE]  = prev_pix[CH_BLUE] + b[1:0] - 8'd2;
          emit_pixels(1);
        end
        OP_LUMA: begin
          chunk  = KIND_LUMA;
          pend   = LUMA_BYTES;
          gdelta = b[5:0];
        end
        default: begin
          emit_pixels(int'(b[5:0]) + 1);
        end
      endcase
    end
  endtask

  task automatic check_pixel(input pix_t want);
    if (red !== want.red) report($sformatf("red got %0h want %0h", red, want.red));
    if (green !== want.green) report($sformatf("green got %0h want %0h", green, want.green));
    if (blue !== want.blue) report($sformatf("blue got %0h want %0h", blue, want.blue));
    if (alpha !== want.alpha) report($sformatf("alpha got %0h want %0h", alpha, want.alpha));
    if (last_of_run !== want.last) begin
      report($sformatf("last_of_run got %0b want %0b", last_of_run, want.last));
    end
    if (image_done !== want.done) begin
      report($sformatf("image_done got %0b want %0b", image_done, want.done));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: follows every handshake at the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    int n_before;
    if (cfg_valid && cfg_ready) begin
      total_reg = cfg_data;
    end
    if (in_valid && in_ready) begin
      n_before = pixels_due.size();
      decode_byte(data_byte, new_image);
      // A directed row with a typed pixel replaces the computed one.
      if (cur_typed) begin
        if (pixels_due.size() != n_before + 1) begin
          report($sformatf("byte %0h gave %0d pixels, one typed", data_byte,
                           pixels_due.size() - n_before));
        end else begin
          pixels_due[n_before] = cur_want;
        end
      end
    end
    if (out_valid && out_ready) begin
      if (pixels_due.size() == 0) begin
        report($sformatf("unexpected pixel %0h %0h %0h %0h", red, green, blue, alpha));
      end else begin
        check_pixel(pixels_due.pop_front());
      end
    end
  end

  // Watchdog: ends the run when no channel has moved an item for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (hold_len - 1) @(negedge clk);
        hold_len = 0;
      end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Moves to the next falling edge, idling the input for a random burst now and then.
  task automatic pace();
    int gap;
    gap = (src_idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Offers one item and holds it until it is accepted.
  task automatic offer(input logic [7:0] b, input logic ni, input logic typed, input pix_t want);
    if (ni || !image_full()) items_sent++;
    in_valid  <= 1'b1;
    data_byte <= b;
    new_image <= ni;
    cur_typed <= typed;
    cur_want  <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops the input and waits until every pixel has come and the block has settled.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_total(input logic [COUNT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sends one chunk with random content; a few are noise or cut short.
  task automatic send_random_chunk();
    logic [7:0] seq [5];
    int         n_seq;
    logic       ni;
    int         pick;
    int         run_len;
    pace();
    ni        = force_new || image_full() || $urandom_range(0, 29) == 0;
    force_new = 1'b0;
    pick      = $urandom_range(0, 99);
    n_seq     = 1;
    if (pick < 20) begin
      seq[0] = {OP_INDEX, 6'($urandom_range(0, 63))};
    end else if (pick < 40) begin
      seq[0] = {OP_DIFF, 6'($urandom)};
    end else if (pick < 58) begin
      seq[0] = {OP_LUMA, 6'($urandom)};
      seq[1] = 8'($urandom);
      n_seq  = 2;
    end else if (pick < 70) begin
      run_len = ($urandom_range(0, 9) == 0) ? 61 : $urandom_range(0, 7);
      seq[0]  = {OP_RUN, 6'(run_len)};
    end else if (pick < 80) begin
      seq[0] = TAG_RGB;
      for (int k = 1; k < 4; k++) seq[k] = 8'($urandom);
      n_seq = 4;
    end else if (pick < 90) begin
      seq[0] = TAG_RGBA;
      for (int k = 1; k < 5; k++) seq[k] = 8'($urandom);
      n_seq = 5;
    end else begin
      seq[0] = 8'($urandom_range(0, 255));
    end
    // Broken sequence: drop the tail of a multi-byte chunk.
    if (n_seq > 1 && $urandom_range(0, 19) == 0) n_seq--;
    for (int k = 0; k < n_seq; k++) begin
      if (k > 0) begin
        pace();
        ni = ($urandom_range(0, 49) == 0);
      end
      offer(seq[k], ni, 1'b0, NO_PIX);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [COUNT_W-1:0] phase_total;
    int                 phase_goal;
    rst       = 1'b1;
    in_valid  = 1'b0;
    data_byte = '0;
    new_image = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    cur_typed = 1'b0;
    cur_want  = NO_PIX;
    total_reg = '0;
    clear_image();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: extremes, every chunk kind, partial chunks and the image end.
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (DIRECTED[r].wr_cfg) begin
        wait_idle();
        write_total(DIRECTED[r].total);
      end
      pace();
      offer(DIRECTED[r].byte_in, DIRECTED[r].ni, DIRECTED[r].typed, DIRECTED[r].want);
    end

    // Random phases, each with its own pixel total; the last one runs without idling.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: phase_total = '0;
        1: phase_total = 29'd400000000;
        2: phase_total = 29'd1;
        3: phase_total = 29'd5;
        4: phase_total = 29'd37;
        5: phase_total = 29'($urandom_range(2, 100));
        default: phase_total = '0;
      endcase
      wait_idle();
      write_total(phase_total);
      src_idle_on = (p != NUM_PHASES - 1);
      snk_idle_on = (p != NUM_PHASES - 1);
      force_new   = 1'b1;
      // Long receiver hold-off while the sender keeps offering, so the input stalls.
      if (p == 4) hold_len = LONG_HOLD;
      phase_goal = items_sent + PHASE_ITEMS;
      while (items_sent < phase_goal) begin
        send_random_chunk();
        // From mid-phase on in phase 1, the sender waits for every pending pixel.
        if (p == 1 && items_sent >= phase_goal - PHASE_ITEMS / 2 && pixels_due.size() != 0) begin
          wait_idle();
        end
      end
    end

    wait_idle();
    if (errors == 0 && pixels_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/qcd_pkg.sv
hw/rtl/qcd_ram.sv
hw/rtl/qcd_ctrl.sv
hw/rtl/qcd_datapath.sv
hw/rtl/qoi_chunk_decoder_unit.sv
sim/tb_qoi_chunk_decoder_unit.sv
